// File: src/pbgd_pkg.sv
// pbgd_pkg: shared types, codes and constants for the push-button group dimmer
// no dependencies

package pbgd_pkg;

  localparam int unsigned LampW = 5;

  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_SWITCH  = 2'd1,
    REQ_PERCENT = 2'd2,
    REQ_MASK    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_ON_LEVEL  = 3'd0,
    CFG_OFF_LEVEL = 3'd1,
    CFG_DMX_MASK  = 3'd2,
    CFG_ACT_LOW   = 3'd3,
    CFG_PRESS_MS  = 3'd4,
    CFG_HOLD_MS   = 3'd5,
    CFG_STEP_MS   = 3'd6,
    CFG_DIM_STEP  = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESSED = 2'd1,
    PH_DIMMING = 2'd2
  } phase_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_TOGGLE = 2'd1,
    OP_DIM    = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] group;
    logic [4:0]  lamp;
    logic [7:0]  level;
    logic        dim_up;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  on_level;
    logic [7:0]  off_level;
    logic [31:0] dmx_mask;
    logic [31:0] act_low_mask;
    logic [15:0] press_ms;
    logic [15:0] hold_ms;
    logic [15:0] step_ms;
    logic [7:0]  dim_step;
  } cfg_t;

  typedef struct packed {
    logic [4:0] out_lamp;
    logic [7:0] out_brightness;
    logic       lamp_on;
    logic       pin_level;
    logic [6:0] report_value;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  button_index;
    logic        pressed;
    logic [31:0] now_ms;
    logic [4:0]  lamp_index;
    logic        switch_on;
    logic [6:0]  percent;
    logic [31:0] group_mask;
  } req_item_t;

  // ceil(p*255/100) saturated at 255, p below 128
  function automatic logic [7:0] pct_level(input logic [6:0] p);
    logic [14:0] prod;
    logic [14:0] q;
    prod = 15'(p) * 15'd255 + 15'd99;
    q    = 15'((32'(prod) * 32'd5243) >> 19);
    if (32'(q) * 32'd100 > 32'(prod)) q = q - 15'd1;
    return (q > 15'd255) ? 8'd255 : q[7:0];
  endfunction

  // floor(b*100/255)
  function automatic logic [6:0] report_pct(input logic [7:0] b);
    logic [14:0] prod;
    logic [31:0] q;
    prod = 15'(b) * 15'd100;
    q    = (32'(prod) * 32'd257) >> 16;
    if ((q + 32'd1) * 32'd255 <= 32'(prod)) q = q + 32'd1;
    return q[6:0];
  endfunction

endpackage

// File: src/pbgd_if.sv
// pbgd_if: valid/ready channel carrying one item of a given payload type
// depends on nothing

interface pbgd_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/pbgd_front.sv
// pbgd_front: button machines, group masks and request classification
// depends on pbgd_pkg

module pbgd_front import pbgd_pkg::*; #(
  parameter int unsigned BUTTONS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_item_t   in_data,
  input  logic        q_ready,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic [7:0]  low_level,
  input  logic        back_idle
);

  localparam int unsigned BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  logic [31:0] group_r [BUTTONS];
  phase_t      phase_r [BUTTONS];
  logic        level_r [BUTTONS];
  logic [31:0] ctime_r [BUTTONS];
  logic [31:0] nstep_r [BUTTONS];
  logic        up_r    [BUTTONS];

  // a dim step needs the group minimum, read by the back after it drains
  typedef enum logic [1:0] {
    FS_RUN  = 2'b01,
    FS_WAIT = 2'b10
  } fstate_t;

  fstate_t     st_r, st_nxt;
  logic [BW-1:0] wb_r;
  logic        wup_r;

  logic        btn_ok;
  logic [BW-1:0] bi;
  logic        lvl;
  logic        released;
  logic [31:0] ct;
  logic [31:0] held;
  logic        dimmable;
  logic        fire;
  cmd_t        cmd;
  logic        emit;
  logic        accept;
  logic [7:0]  new_lvl;
  logic        new_up;

  assign btn_ok = 32'(in_data.button_index) < 32'(BUTTONS);
  assign bi     = BW'(in_data.button_index);
  assign lvl    = in_data.pressed;
  assign released = level_r[bi] && !lvl;
  assign ct     = (lvl != level_r[bi]) ? in_data.now_ms : ctime_r[bi];
  assign held   = in_data.now_ms - ct;
  assign dimmable = ((group_r[bi] & ~cfg.dmx_mask) == 32'd0);

  always_comb begin
    cmd      = '0;
    cmd.lamp = in_data.lamp_index;
    cmd.group = group_r[bi];
    emit     = 1'b0;
    fire     = 1'b0;
    case (req_t'(in_data.req_type))
      REQ_SWITCH: begin
        cmd.op = OP_SINGLE;
        cmd.level = in_data.switch_on ? 8'd255 : cfg.off_level;
        emit = 1'b1;
      end
      REQ_PERCENT: begin
        cmd.op = OP_SINGLE;
        cmd.level = pct_level(in_data.percent);
        emit = 1'b1;
      end
      REQ_SAMPLE: begin
        if (btn_ok && phase_r[bi] == PH_PRESSED && released) begin
          cmd.op = OP_TOGGLE;
          emit = 1'b1;
        end
        if (btn_ok && phase_r[bi] == PH_DIMMING && lvl &&
            held >= nstep_r[bi] + 32'(cfg.step_ms)) begin
          fire = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // dim result from the drained back's group minimum
  always_comb begin
    new_up = wup_r;
    if (wup_r) begin
      new_lvl = (9'(low_level) + 9'(cfg.dim_step) > 9'(cfg.on_level)) ? cfg.on_level
              : 8'(low_level + cfg.dim_step);
      if (new_lvl == cfg.on_level) new_up = 1'b0;
    end else begin
      new_lvl = (low_level > cfg.dim_step) ? 8'(low_level - cfg.dim_step) : 8'd0;
      if (new_lvl == 8'd0) new_up = 1'b1;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    in_ready = 1'b0;
    q_valid  = 1'b0;
    q_cmd    = cmd;
    accept   = 1'b0;
    case (st_r)
      FS_RUN: begin
        in_ready = emit ? q_ready : 1'b1;
        q_valid  = in_valid && emit;
        accept   = in_valid && in_ready;
        if (accept && fire) st_nxt = FS_WAIT;
      end
      FS_WAIT: begin
        q_cmd        = '0;
        q_cmd.op     = OP_DIM;
        q_cmd.group  = group_r[wb_r];
        q_cmd.level  = new_lvl;
        q_cmd.dim_up = new_up;
        q_valid      = back_idle;
        if (back_idle && q_ready) st_nxt = FS_RUN;
      end
      default: st_nxt = FS_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FS_RUN;
      for (int i = 0; i < BUTTONS; i++) begin
        group_r[i] <= '0;
        phase_r[i] <= PH_IDLE;
        level_r[i] <= 1'b0;
        ctime_r[i] <= '0;
        nstep_r[i] <= '0;
        up_r[i]    <= 1'b0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == FS_WAIT && back_idle && q_ready) up_r[wb_r] <= new_up;
      if (accept && btn_ok) begin
        if (req_t'(in_data.req_type) == REQ_MASK) begin
          group_r[bi] <= in_data.group_mask;
        end else if (req_t'(in_data.req_type) == REQ_SAMPLE) begin
          level_r[bi] <= lvl;
          ctime_r[bi] <= ct;
          case (phase_r[bi])
            PH_IDLE: if (lvl && held >= 32'(cfg.press_ms)) phase_r[bi] <= PH_PRESSED;
            PH_PRESSED: begin
              if (released) phase_r[bi] <= PH_IDLE;
              else if (lvl && held >= 32'(cfg.hold_ms) && dimmable) begin
                nstep_r[bi] <= 32'(cfg.hold_ms);
                up_r[bi]    <= 1'b0;
                phase_r[bi] <= PH_DIMMING;
              end
            end
            PH_DIMMING: begin
              if (released) phase_r[bi] <= PH_IDLE;
              if (fire) begin
                nstep_r[bi] <= nstep_r[bi] + 32'(cfg.step_ms);
                wb_r  <= bi;
                wup_r <= up_r[bi];
              end
            end
            default: phase_r[bi] <= PH_IDLE;
          endcase
        end
      end
    end
  end

  a_wait_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r == FS_WAIT && in_ready))
    else $error("front takes an item while a dim step waits");
  a_dim_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_valid && st_r == FS_WAIT && !back_idle))
    else $error("dim step issued before back drained");

endmodule

// File: src/pbgd_queue.sv
// pbgd_queue: two-entry command fifo between front and back
// depends on pbgd_pkg

module pbgd_queue import pbgd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
endmodule

// File: src/pbgd_back.sv
// pbgd_back: lamp level store, toggle scan and group writes
// depends on pbgd_pkg

module pbgd_back import pbgd_pkg::*; #(
  parameter int unsigned LAMPS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [31:0] min_group,
  output logic [7:0]  low_level,
  output logic        idle,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);
  localparam int unsigned SPAN = (LAMPS < 32) ? LAMPS : 32;

  typedef enum logic [3:0] {
    BS_IDLE  = 4'b0001,
    BS_SCAN  = 4'b0010,
    BS_WRITE = 4'b0100,
    BS_ONE   = 4'b1000
  } bstate_t;

  bstate_t     st_r, st_nxt;
  logic [7:0]  lvl_r [LAMPS];
  logic [31:0] grp_r;
  logic [7:0]  val_r;
  logic [4:0]  idx_r;
  logic [5:0]  cnt_r;
  logic        anyon_r;
  logic        ov_r;
  res_t        ores_r;
  logic        can_out;
  logic [31:0] spanmask;
  logic        inb;

  assign spanmask = (SPAN >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SPAN) - 32'd1);
  assign can_out = !ov_r || res_ready;
  assign res_valid = ov_r;
  assign res = ores_r;
  assign idle = (st_r == BS_IDLE) && !ov_r;
  assign cmd_ready = (st_r == BS_IDLE);
  assign inb = 32'(cmd.lamp) < 32'(LAMPS);

  // group minimum, balanced compare tree over the drained store
  always_comb begin
    logic [7:0] t [32];
    for (int i = 0; i < 32; i++)
      t[i] = (i < SPAN && min_group[i]) ? lvl_r[i] : 8'd255;
    for (int w = 16; w >= 1; w = w >> 1)
      for (int i = 0; i < w; i++)
        t[i] = (t[2*i+1] < t[2*i]) ? t[2*i+1] : t[2*i];
    low_level = t[0];
  end

  function automatic res_t mk(input logic [4:0] l, input logic [7:0] b, input logic lst,
                              input cfg_t c);
    res_t r;
    r.out_lamp = l;
    r.out_brightness = b;
    r.lamp_on = b > c.off_level;
    r.pin_level = c.dmx_mask[l] ? 1'b0 : (r.lamp_on ^ c.act_low_mask[l]);
    r.report_value = c.dmx_mask[l] ? report_pct(b) : {6'd0, r.lamp_on};
    r.last = lst;
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BS_IDLE: if (cmd_valid) begin
        if (cmd.op == OP_SINGLE) st_nxt = inb ? BS_ONE : BS_IDLE;
        else if (cmd.op == OP_TOGGLE) st_nxt = BS_SCAN;
        else st_nxt = BS_WRITE;
      end
      BS_SCAN:  if (cnt_r == 6'(SPAN - 1)) st_nxt = BS_WRITE;
      BS_WRITE: if (can_out && (cnt_r == 6'(SPAN - 1))) st_nxt = BS_IDLE;
      BS_ONE:   if (can_out) st_nxt = BS_IDLE;
      default:  st_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
      ov_r <= 1'b0;
      cnt_r <= '0;
      for (int i = 0; i < LAMPS; i++) lvl_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (res_valid && res_ready) ov_r <= 1'b0;
      case (st_r)
        BS_IDLE: if (cmd_valid) begin
          grp_r <= cmd.group;
          val_r <= cmd.level;
          idx_r <= cmd.lamp;
          cnt_r <= '0;
          anyon_r <= 1'b0;
        end
        BS_SCAN: begin
          if (grp_r[cnt_r[4:0]] && lvl_r[cnt_r[4:0]] > cfg.off_level) anyon_r <= 1'b1;
          cnt_r <= (cnt_r == 6'(SPAN - 1)) ? 6'd0 : cnt_r + 6'd1;
          if (cnt_r == 6'(SPAN - 1))
            val_r <= (anyon_r || (grp_r[cnt_r[4:0]] && lvl_r[cnt_r[4:0]] > cfg.off_level))
                   ? cfg.off_level : cfg.on_level;
        end
        BS_WRITE: if (can_out) begin
          if (grp_r[cnt_r[4:0]] && spanmask[cnt_r[4:0]]) begin
            idx_r <= cnt_r[4:0];
            lvl_r[cnt_r[4:0]] <= val_r;
            ores_r <= mk(cnt_r[4:0], val_r,
              (grp_r & spanmask & ~((32'd2 << cnt_r[4:0]) - 32'd1)) == 32'd0, cfg);
            ov_r <= 1'b1;
          end
          cnt_r <= cnt_r + 6'd1;
        end
        BS_ONE: if (can_out) begin
          lvl_r[idx_r] <= val_r;
          ores_r <= mk(idx_r, val_r, 1'b1, cfg);
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_scan_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BS_SCAN |=> st_r != BS_IDLE)
    else $error("toggle scan ended without writes");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> $stable(ores_r))
    else $error("result changed while stalled");
endmodule

// File: src/push_button_group_dimmer_core.sv
// Push-button group dimmer: per-button press/hold machines drive lamp groups
// sharing a LAMPS-entry brightness store. A toggle scans the group for any lit
// lamp, then writes the lamps one write slot per lamp; a dim step first waits until
// the queue and the back are empty. Output stalls stretch each write slot. The
// back's single lamp scanner sets the rate; the two-entry queue lets buttons and
// mask loads that write nothing pass while a group is written.
// depends on pbgd_pkg, pbgd_if, pbgd_front, pbgd_queue, pbgd_back

module push_button_group_dimmer_core import pbgd_pkg::*; #(
  parameter int unsigned LAMPS   = 32,
  parameter int unsigned BUTTONS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pbgd_if.sink        in_ch,
  pbgd_if.source      out_ch
);
  cfg_t  cfg_r;
  logic  qi_valid, qi_ready, qo_valid, qo_ready;
  cmd_t  qi_cmd, qo_cmd;
  logic [7:0]  low;
  logic        bidle;
  logic        drained;
  logic [31:0] mg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{on_level: 8'd255, off_level: 8'd0, dmx_mask: '0, act_low_mask: '0,
                 press_ms: 16'd40, hold_ms: 16'd600, step_ms: 16'd500, dim_step: 8'd30};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ON_LEVEL:  cfg_r.on_level     <= cfg_data[7:0];
        CFG_OFF_LEVEL: cfg_r.off_level    <= cfg_data[7:0];
        CFG_DMX_MASK:  cfg_r.dmx_mask     <= cfg_data;
        CFG_ACT_LOW:   cfg_r.act_low_mask <= cfg_data;
        CFG_PRESS_MS:  cfg_r.press_ms     <= cfg_data[15:0];
        CFG_HOLD_MS:   cfg_r.hold_ms      <= cfg_data[15:0];
        CFG_STEP_MS:   cfg_r.step_ms      <= cfg_data[15:0];
        CFG_DIM_STEP:  cfg_r.dim_step     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // dim steps are issued only with an empty queue and idle back
  assign drained = bidle && !qo_valid;

  pbgd_front #(.BUTTONS(BUTTONS)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_ready(qi_ready), .q_valid(qi_valid), .q_cmd(qi_cmd),
    .low_level(low), .back_idle(drained)
  );

  assign mg = qi_cmd.group;

  pbgd_queue u_queue (
    .clk, .rst_n,
    .wr_valid(qi_valid), .wr_ready(qi_ready), .wr_data(qi_cmd),
    .rd_valid(qo_valid), .rd_ready(qo_ready), .rd_data(qo_cmd)
  );

  pbgd_back #(.LAMPS(LAMPS)) u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .cmd_valid(qo_valid), .cmd_ready(qo_ready), .cmd(qo_cmd),
    .min_group(mg), .low_level(low), .idle(bidle),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );

  a_dim_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !(qo_valid && qo_ready && qo_cmd.op == OP_DIM && out_ch.valid))
    else $error("dim step started with a result pending");
endmodule
